// File: hw/rtl/sid_pkg.sv
// shared types and constants for the signed integer divider
package sid_pkg;

    localparam int SID_DATA_WIDTH = 32;

    // per-beat status carried alongside the partial results
    typedef struct packed {
        logic neg_quo;   // operand signs differ
        logic div_zero;  // divisor was zero
    } t_sid_flags;

endpackage

// File: hw/rtl/signed_integer_divider.sv
// signed integer divider: pipelined restoring division of operand magnitudes
// a beat passes the input register, one subtract stage per quotient bit, then the output register
// throughput: one beat per cycle while the output side keeps taking beats
// depth is set by one restoring subtract step per pipeline stage, plus sign stages
// a stalled output freezes every stage at once; nothing is dropped or repeated
// reset (synchronous, active low) clears the valid bits only
module signed_integer_divider
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = SID_DATA_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input beat
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0]     i_s_tdata,
                                                  // dividend, divisor, zero pad
    // output beat
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [((2 * DATA_WIDTH - 1 + 7) / 8) * 8 - 1:0] o_m_tdata,
                                                  // quotient, remainder_magnitude, zero pad
    output logic [1:0]               o_m_tuser    // divide_by_zero, overflow
);

    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8;
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // whole pipe moves when the output register is empty or being drained
    logic w_advance;

    // stage 0: magnitudes, sign and zero-divisor flags
    logic                  r_in_valid;
    t_sid_flags            r_in_flags;
    logic [DATA_WIDTH-1:0] r_in_dvd;
    logic [DATA_WIDTH-1:0] r_in_dvs;

    logic [DATA_WIDTH-1:0] w_dividend;
    logic [DATA_WIDTH-1:0] w_divisor;
    logic [DATA_WIDTH-1:0] n_in_dvd;
    logic [DATA_WIDTH-1:0] n_in_dvs;
    t_sid_flags            n_in_flags;

    // stage chain, index 0 is stage 0, index DATA_WIDTH is the last step
    logic                  s_valid [0:DATA_WIDTH];
    t_sid_flags            s_flags [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_quo   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_dvd   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_dvs   [0:DATA_WIDTH];

    // output register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_quo;
    logic [DATA_WIDTH-2:0] r_out_rem;
    logic                  r_out_dz;
    logic                  r_out_ovf;

    logic [DATA_WIDTH-1:0] n_out_quo;
    logic [DATA_WIDTH-2:0] n_out_rem;
    logic                  n_out_dz;
    logic                  n_out_ovf;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = w_advance;

    // operand split and magnitude; most negative maps onto the sign bit pattern
    always_comb begin
        w_dividend          = i_s_tdata[DATA_WIDTH-1:0];
        w_divisor           = i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        n_in_dvd            = w_dividend[DATA_WIDTH-1] ? (~w_dividend + 1'b1) : w_dividend;
        n_in_dvs            = w_divisor[DATA_WIDTH-1] ? (~w_divisor + 1'b1) : w_divisor;
        n_in_flags.neg_quo  = w_dividend[DATA_WIDTH-1] ^ w_divisor[DATA_WIDTH-1];
        n_in_flags.div_zero = (w_divisor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_advance) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_in_flags <= n_in_flags;
            r_in_dvd   <= n_in_dvd;
            r_in_dvs   <= n_in_dvs;
        end
    end

    assign s_valid[0] = r_in_valid;
    assign s_flags[0] = r_in_flags;
    assign s_rem[0]   = '0;
    assign s_quo[0]   = '0;
    assign s_dvd[0]   = r_in_dvd;
    assign s_dvs[0]   = r_in_dvs;

    // one quotient bit per stage, msb first
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        sid_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_valid   (s_valid[g]),
            .i_flags   (s_flags[g]),
            .i_rem     (s_rem[g]),
            .i_quo     (s_quo[g]),
            .i_dvd     (s_dvd[g]),
            .i_dvs     (s_dvs[g]),
            .o_valid   (s_valid[g+1]),
            .o_flags   (s_flags[g+1]),
            .o_rem     (s_rem[g+1]),
            .o_quo     (s_quo[g+1]),
            .o_dvd     (s_dvd[g+1]),
            .o_dvs     (s_dvs[g+1])
        );
    end

    // sign fix-up, saturation of most negative over minus one, zero divisor clamp
    always_comb begin
        n_out_dz  = s_flags[DATA_WIDTH].div_zero;
        n_out_ovf = 1'b0;
        n_out_rem = s_rem[DATA_WIDTH][DATA_WIDTH-2:0];
        if (s_flags[DATA_WIDTH].div_zero) begin
            n_out_quo = '0;
            n_out_rem = '0;
        end else if (s_flags[DATA_WIDTH].neg_quo) begin
            n_out_quo = ~s_quo[DATA_WIDTH] + 1'b1;
        end else if (s_quo[DATA_WIDTH][DATA_WIDTH-1]) begin
            n_out_quo = MAX_POS;
            n_out_ovf = 1'b1;
        end else begin
            n_out_quo = s_quo[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= s_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_quo <= n_out_quo;
            r_out_rem <= n_out_rem;
            r_out_dz  <= n_out_dz;
            r_out_ovf <= n_out_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_rem, r_out_quo});
    assign o_m_tuser  = {r_out_ovf, r_out_dz};

    // zero divisor and saturation never flag together
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(r_out_dz && r_out_ovf))
        else $error("divide by zero and overflow both set");

    // zero divisor clears both data fields
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_dz) |-> (r_out_quo == '0 && r_out_rem == '0))
        else $error("divide by zero result not cleared");

    // saturation gives the largest positive quotient and no remainder
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_ovf) |-> (r_out_quo == MAX_POS && r_out_rem == '0))
        else $error("overflow result not saturated");

    // a held output beat backs up the input side
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while output stalled");

endmodule

// File: hw/rtl/sid_stage.sv
// one restoring shift-and-subtract step of the divider pipeline
module sid_stage
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = SID_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_valid,
    input  t_sid_flags            i_flags,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_quo,
    input  logic [DATA_WIDTH-1:0] i_dvd,
    input  logic [DATA_WIDTH-1:0] i_dvs,
    output logic                  o_valid,
    output t_sid_flags            o_flags,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_dvd,
    output logic [DATA_WIDTH-1:0] o_dvs
);

    logic                  r_valid;
    t_sid_flags            r_flags;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_dvd;
    logic [DATA_WIDTH-1:0] r_dvs;

    logic [DATA_WIDTH-1:0] w_trial;
    logic                  w_ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;

    // partial remainder stays below the divisor, so its top bit is free
    always_comb begin
        w_trial = {i_rem[DATA_WIDTH-2:0], i_dvd[DATA_WIDTH-1]};
        w_ge    = (w_trial >= i_dvs);
        n_rem   = w_ge ? (w_trial - i_dvs) : w_trial;
        n_quo   = {i_quo[DATA_WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_dvd   <= {i_dvd[DATA_WIDTH-2:0], 1'b0};
            r_dvs   <= i_dvs;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dvd   = r_dvd;
    assign o_dvs   = r_dvs;

endmodule
